### sv/slab_object_allocator_top_macros.svh
// Assertion macros for the slab allocator
`ifndef SLAB_OBJECT_ALLOCATOR_TOP_MACROS_SVH
`define SLAB_OBJECT_ALLOCATOR_TOP_MACROS_SVH
`ifndef SYNTH
`define SOA_ASSERT_IMPL(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define SOA_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define SOA_ASSERT_IMPL(label, clk, rst_n, a, c, msg)
`define SOA_ASSERT_NEXT(label, clk, rst_n, a, c, msg)
`endif
`endif

### sv/soa_pkg.sv
package soa_pkg;

	localparam int SLOTS_MAX = 512;

	typedef struct packed {
		logic        kind;
		logic [12:0] object_id;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [12:0] result_id;
		logic [15:0] byte_address;
		logic [4:0]  slabs_in_use;
	} rsp_t;

	localparam logic [1:0] ST_ALLOC = 2'd0;
	localparam logic [1:0] ST_FREED = 2'd1;
	localparam logic [1:0] ST_REAPED = 2'd2;
	localparam logic [1:0] ST_OOM = 2'd3;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE = 1'b1;

	localparam logic CFG_OBJ_BYTES = 1'b0;
	localparam logic CFG_OBJ_PER_SLAB = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_POP_RD,
		S_POP_WAIT,
		S_INIT,
		S_FREE,
		S_REAP_RD,
		S_REAP_WAIT,
		S_REAP_STEP,
		S_ADDR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic latch;
		logic pop_rd;
		logic pop_take;
		logic claim;
		logic init_wr;
		logic push;
		logic reap_begin;
		logic reap_step;
		logic reap_end;
		logic calc_addr;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic kind;
		logic head_valid;
		logic slab_free;
		logic free_ok;
		logic ref_zero;
		logic init_last;
		logic walk_more;
	} sts_t;

endpackage

### sv/soa_ctrl.sv
module soa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  soa_pkg::sts_t  sts,
	output soa_pkg::cmd_t  cmd
);

	soa_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= soa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			soa_pkg::S_IDLE: if (start) state_d = soa_pkg::S_DECODE;
			soa_pkg::S_DECODE: begin
				if (sts.kind == soa_pkg::KIND_FREE) state_d = soa_pkg::S_FREE;
				else if (sts.head_valid) state_d = soa_pkg::S_POP_RD;
				else if (sts.slab_free) state_d = soa_pkg::S_INIT;
				else state_d = soa_pkg::S_DONE;
			end
			soa_pkg::S_POP_RD: state_d = soa_pkg::S_POP_WAIT;
			soa_pkg::S_POP_WAIT: state_d = soa_pkg::S_ADDR;
			soa_pkg::S_INIT: if (sts.init_last) state_d = soa_pkg::S_ADDR;
			soa_pkg::S_FREE: begin
				if (!sts.free_ok) state_d = soa_pkg::S_DONE;
				else if (sts.ref_zero) state_d = soa_pkg::S_REAP_RD;
				else state_d = soa_pkg::S_DONE;
			end
			soa_pkg::S_REAP_RD: begin
				if (sts.walk_more) state_d = soa_pkg::S_REAP_WAIT;
				else state_d = soa_pkg::S_DONE;
			end
			soa_pkg::S_REAP_WAIT: state_d = soa_pkg::S_REAP_STEP;
			soa_pkg::S_REAP_STEP: state_d = soa_pkg::S_REAP_RD;
			soa_pkg::S_ADDR: state_d = soa_pkg::S_DONE;
			soa_pkg::S_DONE: state_d = soa_pkg::S_IDLE;
			default: state_d = soa_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = (state_q != soa_pkg::S_IDLE);
		unique case (state_q)
			soa_pkg::S_IDLE: cmd.latch = start;
			soa_pkg::S_DECODE: begin
				if (sts.kind == soa_pkg::KIND_ALLOC && !sts.head_valid && sts.slab_free)
					cmd.claim = 1'b1;
			end
			soa_pkg::S_POP_RD: cmd.pop_rd = 1'b1;
			soa_pkg::S_POP_WAIT: cmd.pop_take = 1'b1;
			soa_pkg::S_INIT: cmd.init_wr = 1'b1;
			soa_pkg::S_FREE: begin
				cmd.push = sts.free_ok;
				cmd.reap_begin = sts.free_ok && sts.ref_zero;
			end
			soa_pkg::S_REAP_RD: cmd.reap_end = !sts.walk_more;
			soa_pkg::S_REAP_STEP: cmd.reap_step = 1'b1;
			soa_pkg::S_ADDR: cmd.calc_addr = 1'b1;
			soa_pkg::S_DONE: cmd.emit = 1'b1;
			default: cmd = '0;
		endcase
	end

endmodule

### sv/soa_datapath.sv
module soa_datapath #(
	parameter int SLABS = 16,
	parameter int SLAB_BYTES = 4096
) (
	input  logic           clk,
	input  logic           arst_n,
	input  soa_pkg::req_t  req,
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic [11:0]    cfg_data,
	input  soa_pkg::cmd_t  cmd,
	output soa_pkg::sts_t  sts,
	output logic           result_strobe,
	output soa_pkg::rsp_t  result
);

	localparam int SW = (SLABS > 1) ? $clog2(SLABS) : 1;
	localparam int TW = $clog2(soa_pkg::SLOTS_MAX);
	localparam int OW = SW + TW;
	localparam int TOTAL = SLABS * soa_pkg::SLOTS_MAX;
	localparam int LW = OW + 1;
	localparam int NW = TW + 1;
	localparam int CW = $clog2(SLABS + 1);
	localparam int STEPW = $clog2(TOTAL + 1);

	// link memory: nil is the top bit set
	logic [LW-1:0] mem [TOTAL];
	logic [LW-1:0] rd_q;
	logic          we;
	logic [OW-1:0] waddr;
	logic [LW-1:0] wdata;
	logic [OW-1:0] raddr;

	logic [11:0]   obj_bytes_q;
	logic [8:0]    per_slab_q;
	logic          kind_q;
	logic [12:0]   oid_q;
	logic [LW-1:0] head_q;
	logic [9:0]    ref_q [SLABS];
	logic [SLABS-1:0] claimed_q;
	logic [CW-1:0] count_q;
	logic [1:0]    status_q;
	logic [OW-1:0] rid_q;
	logic [15:0]   addr_q;
	logic [SW-1:0] sel_slab;
	logic          any_free;
	logic [NW-1:0] n_cl;
	logic [TW-1:0] init_i_q;
	logic [SW-1:0] slab_q;
	logic [LW-1:0] cur_q;
	logic [LW-1:0] prev_q;
	logic [STEPW-1:0] steps_q;
	logic [SW-1:0] fslab;
	logic          fok;
	logic [9:0]    ref_dec;

	always_comb begin
		sel_slab = '0;
		any_free = 1'b0;
		for (int s = SLABS - 1; s >= 0; s--) begin
			if (!claimed_q[s]) begin
				sel_slab = SW'(s);
				any_free = 1'b1;
			end
		end
	end

	always_comb begin
		if (per_slab_q == 9'd0) n_cl = NW'(1);
		else if ({{(NW+9){1'b0}}, per_slab_q} > (NW+18)'(soa_pkg::SLOTS_MAX))
			n_cl = NW'(soa_pkg::SLOTS_MAX);
		else n_cl = NW'(per_slab_q);
	end

	assign fslab = SW'(oid_q >> TW);
	assign fok = ({19'd0, oid_q} < 32'(TOTAL)) && claimed_q[fslab];
	assign ref_dec = ref_q[fslab] - 10'd1;

	assign sts.kind = kind_q;
	assign sts.head_valid = !head_q[LW-1];
	assign sts.slab_free = any_free;
	assign sts.free_ok = fok;
	assign sts.ref_zero = (ref_dec == 10'd0);
	assign sts.init_last = ({1'b0, init_i_q} + NW'(1) >= n_cl);
	assign sts.walk_more = !cur_q[LW-1] && ({1'b0, steps_q} < (STEPW+1)'(TOTAL));

	always_comb begin
		we = 1'b0;
		waddr = '0;
		wdata = '0;
		if (cmd.init_wr && n_cl > NW'(1)) begin
			we = 1'b1;
			waddr = {slab_q, init_i_q};
			if ({1'b0, init_i_q} + NW'(1) >= n_cl) wdata = {1'b1, {OW{1'b0}}};
			else wdata = {1'b0, slab_q, init_i_q + TW'(1)};
		end else if (cmd.push) begin
			we = 1'b1;
			waddr = OW'(oid_q);
			wdata = head_q;
		end else if (cmd.reap_step && rid_q[SW+TW-1 -: SW] == slab_q
				&& !prev_q[LW-1] && cur_q[OW-1 -: SW] == slab_q) begin
			we = 1'b1;
			waddr = prev_q[OW-1:0];
			wdata = rd_q;
		end
		raddr = cmd.pop_rd ? head_q[OW-1:0] : cur_q[OW-1:0];
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obj_bytes_q <= 12'd8;
			per_slab_q <= 9'd511;
			head_q <= {1'b1, {OW{1'b0}}};
			claimed_q <= '0;
			count_q <= '0;
			result_strobe <= 1'b0;
			for (int s = 0; s < SLABS; s++) ref_q[s] <= '0;
		end else begin
			result_strobe <= cmd.emit;
			if (cfg_we) begin
				if (cfg_index == soa_pkg::CFG_OBJ_BYTES) obj_bytes_q <= cfg_data;
				else per_slab_q <= cfg_data[8:0];
			end
			if (cmd.pop_take) begin
				head_q <= rd_q;
				ref_q[rid_q[OW-1 -: SW]] <= ref_q[rid_q[OW-1 -: SW]] + 10'd1;
			end
			if (cmd.claim) begin
				claimed_q[sel_slab] <= 1'b1;
				count_q <= count_q + CW'(1);
				ref_q[sel_slab] <= 10'd1;
				if (n_cl > NW'(1)) head_q <= {1'b0, sel_slab, TW'(1)};
			end
			if (cmd.push) begin
				head_q <= {1'b0, OW'(oid_q)};
				ref_q[fslab] <= ref_dec;
			end
			// unlink head entries of the reaped slab
			if (cmd.reap_step && cur_q[OW-1 -: SW] == slab_q && prev_q[LW-1])
				head_q <= rd_q;
			if (cmd.reap_end) begin
				claimed_q[slab_q] <= 1'b0;
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q <= req.kind;
			oid_q <= req.object_id;
			status_q <= soa_pkg::ST_ALLOC;
			rid_q <= '0;
			addr_q <= '0;
		end
		if (cmd.pop_rd) rid_q <= head_q[OW-1:0];
		if (cmd.claim) begin
			slab_q <= sel_slab;
			rid_q <= {sel_slab, {TW{1'b0}}};
			init_i_q <= TW'(1);
		end
		if (cmd.init_wr) init_i_q <= init_i_q + TW'(1);
		if (sts.kind == soa_pkg::KIND_ALLOC && !sts.head_valid && !any_free && cmd == '0
				&& !cmd.latch)
			status_q <= soa_pkg::ST_OOM;
		if (!cmd.reap_begin && (cmd.push || (kind_q == soa_pkg::KIND_FREE && !cmd.latch
				&& !cmd.emit && status_q == soa_pkg::ST_ALLOC)))
			status_q <= soa_pkg::ST_FREED;
		if (cmd.reap_begin) begin
			status_q <= soa_pkg::ST_REAPED;
			slab_q <= fslab;
			// keep slab in rid bits so write mux can test reaping
			rid_q <= {fslab, {TW{1'b0}}};
			cur_q <= {1'b0, OW'(oid_q)};
			prev_q <= {1'b1, {OW{1'b0}}};
			steps_q <= '0;
		end
		if (cmd.reap_step) begin
			if (cur_q[OW-1 -: SW] != slab_q) prev_q <= cur_q;
			cur_q <= rd_q;
			steps_q <= steps_q + STEPW'(1);
		end
		if (cmd.calc_addr)
			addr_q <= 16'(24'(rid_q[OW-1 -: SW]) * 24'(SLAB_BYTES)
				+ 24'(rid_q[TW-1:0]) * 24'(obj_bytes_q));
	end

	always_comb begin
		result.status = status_q;
		result.result_id = (status_q == soa_pkg::ST_ALLOC) ? 13'(rid_q) : 13'd0;
		result.byte_address = (status_q == soa_pkg::ST_ALLOC) ? addr_q : 16'd0;
		result.slabs_in_use = 5'(count_q);
	end

endmodule

### sv/slab_object_allocator_top.sv
// Steps after decode: list alloc pops, then address; free pushes; out of slabs none.
// Slab claim: list init for n objects per slab, one link write a cycle, then address.
// Reap adds a list walk, read, wait and step per entry, over the one link memory port.
// Each ends in the strobe. One request at a time; busy drops in the strobe cycle.
// arst_n clears list head, claims and refcounts; link memory is not cleared.
// Results are strobed for one cycle; the receiver cannot stall.
`include "slab_object_allocator_top_macros.svh"
module slab_object_allocator_top #(
	parameter int SLABS = 16,
	parameter int SLAB_BYTES = 4096
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  soa_pkg::req_t  request,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic           cfg_index,
	input  logic [11:0]    cfg_data,
	output logic           result_strobe,
	output soa_pkg::rsp_t  result
);

	soa_pkg::cmd_t cmd;
	soa_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	soa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
	);

	soa_datapath #(.SLABS(SLABS), .SLAB_BYTES(SLAB_BYTES)) u_dp (
		.clk(clk), .arst_n(arst_n), .req(request),
		.cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.cmd(cmd), .sts(sts), .result_strobe(result_strobe), .result(result)
	);

	`SOA_ASSERT_NEXT(a_strobe_one, clk, arst_n, result_strobe, !result_strobe, "double strobe")
	`SOA_ASSERT_NEXT(a_busy_start, clk, arst_n, start && !busy, busy, "no busy after accept")
	`SOA_ASSERT_IMPL(a_oom_id, clk, arst_n, result_strobe && result.status != soa_pkg::ST_ALLOC, result.result_id == 13'd0, "nonzero id")

endmodule

### verif/slab_object_allocator_top_tb.sv
class slab_scoreboard;
	int                  link[8192];
	int                  head;
	bit [9:0]            refc[16];
	bit [15:0]           claimed;
	int                  nclaimed;
	int                  obj_bytes;
	int                  obj_per_slab;
	soa_pkg::rsp_t       pending[$];
	int                  errors;

	function new();
		head = -1;
		claimed = '0;
		nclaimed = 0;
		obj_bytes = 8;
		obj_per_slab = 511;
		errors = 0;
		foreach (refc[i]) refc[i] = '0;
		foreach (link[i]) link[i] = 0;
	endfunction

	function void set_reg(logic idx, logic [11:0] d);
		if (idx == soa_pkg::CFG_OBJ_BYTES) obj_bytes = d;
		else obj_per_slab = d[8:0];
	endfunction

	function void unlink_slab(int s);
		int cur;
		int prev;
		int nxt;
		int steps;
		cur = head;
		prev = -1;
		steps = 0;
		while (cur >= 0 && cur < 8192 && steps < 8192) begin
			nxt = link[cur];
			if (cur / 512 == s) begin
				if (prev < 0) head = nxt;
				else link[prev] = nxt;
			end else begin
				prev = cur;
			end
			cur = nxt;
			steps++;
		end
		claimed[s] = 1'b0;
		nclaimed--;
	endfunction

	function soa_pkg::rsp_t note(soa_pkg::req_t r);
		soa_pkg::rsp_t e;
		int s;
		int n;
		int base;
		int rid;
		e = '0;
		rid = 0;
		e.status = soa_pkg::ST_ALLOC;
		if (r.kind == soa_pkg::KIND_ALLOC) begin
			if (head >= 0 && head < 8192) begin
				rid = head;
				head = link[rid];
			end else begin
				for (s = 0; s < 16; s++)
					if (!claimed[s]) break;
				if (s >= 16) begin
					e.status = soa_pkg::ST_OOM;
				end else begin
					n = obj_per_slab;
					if (n < 1) n = 1;
					if (n > 512) n = 512;
					base = s * 512;
					claimed[s] = 1'b1;
					nclaimed++;
					refc[s] = '0;
					for (int i = 1; i + 1 < n; i++) link[base + i] = base + i + 1;
					if (n > 1) begin
						link[base + n - 1] = -1;
						head = base + 1;
					end else begin
						head = -1;
					end
					rid = base;
				end
			end
			if (e.status == soa_pkg::ST_ALLOC) begin
				s = rid / 512;
				refc[s] = refc[s] + 10'd1;
				e.result_id = 13'(rid);
				e.byte_address = 16'(s * 4096 + (rid % 512) * obj_bytes);
			end
		end else begin
			s = r.object_id / 512;
			e.status = soa_pkg::ST_FREED;
			if (claimed[s]) begin
				link[r.object_id] = head;
				head = r.object_id;
				refc[s] = refc[s] - 10'd1;
				if (refc[s] == 0) begin
					unlink_slab(s);
					e.status = soa_pkg::ST_REAPED;
				end
			end
		end
		e.slabs_in_use = 5'(nclaimed);
		pending.push_back(e);
		return e;
	endfunction

	function void check(soa_pkg::rsp_t a);
		soa_pkg::rsp_t e;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result %h", $time, a);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (a.status !== e.status) begin
			$display("%0t: status exp %0d got %0d", $time, e.status, a.status);
			errors++;
		end
		if (a.result_id !== e.result_id) begin
			$display("%0t: result_id exp %0d got %0d", $time, e.result_id, a.result_id);
			errors++;
		end
		if (a.byte_address !== e.byte_address) begin
			$display("%0t: byte_address exp %h got %h", $time, e.byte_address,
				a.byte_address);
			errors++;
		end
		if (a.slabs_in_use !== e.slabs_in_use) begin
			$display("%0t: slabs_in_use exp %0d got %0d", $time, e.slabs_in_use,
				a.slabs_in_use);
			errors++;
		end
	endfunction
endclass

module slab_object_allocator_top_tb;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	soa_pkg::req_t request;
	logic          cfg_valid;
	logic          cfg_ready;
	logic          cfg_index;
	logic [11:0]   cfg_data;
	logic          result_strobe;
	soa_pkg::rsp_t result;

	slab_scoreboard sb;
	int          live[$];
	bit          gaps_on;

	slab_object_allocator_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.result_strobe(result_strobe),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#2000000000;
		$display("TEST FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && result_strobe) sb.check(result);
	end

	task automatic send(logic k, logic [12:0] id);
		soa_pkg::req_t r;
		soa_pkg::rsp_t e;
		r.kind = k;
		r.object_id = id;
		start <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy);
		e = sb.note(r);
		if (e.status == soa_pkg::ST_ALLOC) live.push_back(e.result_id);
		if (e.status == soa_pkg::ST_REAPED) begin
			for (int i = live.size() - 1; i >= 0; i--)
				if (live[i] / 512 == id / 512) live.delete(i);
		end
		if (gaps_on && $urandom_range(3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(13, 1)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0 || busy) @(posedge clk);
		// let a trailing reap walk settle
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [11:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_reg(idx, d);
		@(posedge clk);
	endtask

	task automatic random_item(int alloc_pct);
		int pick;
		int j;
		pick = $urandom_range(99);
		if (pick < alloc_pct || live.size() == 0 && pick < 90) begin
			send(soa_pkg::KIND_ALLOC, 13'($urandom));
		end else if (pick < 92 && live.size() != 0) begin
			j = $urandom_range(live.size() - 1);
			pick = live[j];
			live.delete(j);
			send(soa_pkg::KIND_FREE, 13'(pick));
		end else if (pick < 96) begin
			send(soa_pkg::KIND_FREE, 13'($urandom));
		end else begin
			// hit one of slabs 0 to 3 at a random slot, possibly a double free
			send(soa_pkg::KIND_FREE, 13'({$urandom_range(3), 9'($urandom)}));
		end
	endtask

	initial begin
		logic [11:0] ob_tab[5];
		logic [11:0] n_tab[6];
		int          cnt;
		int          pct;
		ob_tab = '{12'd8, 12'd2048, 12'd4095, 12'd24, 12'd8};
		n_tab = '{12'd2, 12'd0, 12'd1, 12'hE05, 12'h7FF, 12'd2};
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		cfg_valid = 1'b0;
		cfg_index = soa_pkg::CFG_OBJ_BYTES;
		cfg_data = '0;
		gaps_on = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unclaimed frees, then a claim at reset settings
		send(soa_pkg::KIND_FREE, 13'h1FFF);
		send(soa_pkg::KIND_FREE, 13'd0);
		send(soa_pkg::KIND_ALLOC, 13'd0);
		drain();
		write_reg(soa_pkg::CFG_OBJ_BYTES, 12'd2048);
		write_reg(soa_pkg::CFG_OBJ_PER_SLAB, 12'd2);
		send(soa_pkg::KIND_ALLOC, 13'd0);
		send(soa_pkg::KIND_ALLOC, 13'd0);
		send(soa_pkg::KIND_FREE, 13'd1);
		send(soa_pkg::KIND_FREE, 13'd511);
		send(soa_pkg::KIND_FREE, 13'd0);
		send(soa_pkg::KIND_FREE, 13'd512);
		send(soa_pkg::KIND_FREE, 13'd513);
		send(soa_pkg::KIND_ALLOC, 13'd0);
		send(soa_pkg::KIND_ALLOC, 13'd0);
		send(soa_pkg::KIND_FREE, 13'd1);
		send(soa_pkg::KIND_FREE, 13'd1);
		send(soa_pkg::KIND_ALLOC, 13'd0);
		drain();
		write_reg(soa_pkg::CFG_OBJ_PER_SLAB, 12'd1);
		write_reg(soa_pkg::CFG_OBJ_BYTES, 12'd4095);
		repeat (17) send(soa_pkg::KIND_ALLOC, 13'd0);
		send(soa_pkg::KIND_FREE, 13'd512);
		send(soa_pkg::KIND_FREE, 13'd7680);
		drain();
		live.delete();
		for (int i = 0; i < 15; i++) begin
			if (i == 15 - 1) live.delete();
			write_reg(soa_pkg::CFG_OBJ_BYTES, (i % 5 == 4) ? 12'($urandom) : ob_tab[i % 5]);
			if (i % 6 == 5) write_reg(soa_pkg::CFG_OBJ_PER_SLAB, 12'($urandom_range(40, 2)));
			else write_reg(soa_pkg::CFG_OBJ_PER_SLAB, n_tab[i % 6]);
			cnt = (n_tab[i % 6] == 12'h7FF) ? 40 : 100;
			gaps_on = (i < 12) ? ($urandom_range(4) != 0) : 1'b0;
			for (int k = 0; k < cnt; k++) begin
				if (k % 25 == 0) pct = $urandom_range(80, 25);
				random_item(pct);
			end
			drain();
		end
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

### sim.f
+incdir+sv
sv/soa_pkg.sv
sv/soa_ctrl.sv
sv/soa_datapath.sv
sv/slab_object_allocator_top.sv
verif/slab_object_allocator_top_tb.sv
